// ===== sv/npcs_pkg.sv =====
package npcs_pkg;

  localparam int unsigned CH_W    = 6;
  localparam int unsigned SQ_W    = 2 * CH_W;
  // three squared differences of up to 63*63 each
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned ENTRY_W = 8;

  localparam logic [CH_W-1:0]    CHANNEL_MAX  = 6'd63;
  localparam logic [ENTRY_W-1:0] SEARCH_RESET = 8'd253;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // tracks one palette read through the datapath
  typedef struct packed {
    logic               valid;
    logic [ENTRY_W-1:0] idx;
  } token_t;

  function automatic logic [CH_W-1:0] sat_channel(input logic [ENTRY_W-1:0] v);
    logic [CH_W-1:0] res;
    if (v > ENTRY_W'(CHANNEL_MAX)) begin
      res = CHANNEL_MAX;
    end else begin
      res = v[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/npcs_palette_mem.sv =====
module npcs_palette_mem import npcs_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  rgb_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output rgb_t          rdata_o
);

  rgb_t mem [DEPTH];
  rgb_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/npcs_dist_unit.sv =====
module npcs_dist_unit import npcs_pkg::*; (
  input  logic              clk_i,
  input  rgb_t              entry_i,
  input  rgb_t              query_i,
  output logic [DIST_W-1:0] dist_o
);

  logic [CH_W-1:0] dr, dg, db;
  logic [SQ_W-1:0] sq_r_q, sq_g_q, sq_b_q;

  always_comb begin
    dr = (entry_i.red   > query_i.red)   ? entry_i.red   - query_i.red
                                         : query_i.red   - entry_i.red;
    dg = (entry_i.green > query_i.green) ? entry_i.green - query_i.green
                                         : query_i.green - entry_i.green;
    db = (entry_i.blue  > query_i.blue)  ? entry_i.blue  - query_i.blue
                                         : query_i.blue  - entry_i.blue;
  end

  // squares registered before the sum
  always_ff @(posedge clk_i) begin
    sq_r_q <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_q <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_q <= SQ_W'(db) * SQ_W'(db);
  end

  assign dist_o = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

endmodule

// ===== sv/nearest_palette_color_search.sv =====
// nearest palette color search
//
// input channel (in_valid_i / in_stall_o): one item per transfer. op_i selects
// a palette write (entry_index_i, channels saturated to 63) or a query (low six
// bits of each channel). a write completes in the transfer cycle and gives no
// result. a query gives one closest_index_o transfer on the output channel.
// config channel (cfg_valid_i / cfg_ready_o): always ready, loads the highest
// searched palette index; takes effect for the next query.
// search: a query walks entries 0..last at one distance per cycle through the
// single palette read port and one shared distance unit; the input stalls from
// the query's transfer until its result is loaded into the output register, so
// no new item is taken during a search. writes go one per cycle while idle.
// stall: a result waits in the output register while out_stall_i is high; a
// new item is taken meanwhile, and a finished query holds until the register
// frees. reset empties the output register, sets the search bound to 253 and
// leaves the palette contents undefined until written.
module nearest_palette_color_search import npcs_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ENTRY_W-1:0]  cfg_data_i,
  // item input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [ENTRY_W-1:0]  entry_index_i,
  input  logic [ENTRY_W-1:0]  red_i,
  input  logic [ENTRY_W-1:0]  green_i,
  input  logic [ENTRY_W-1:0]  blue_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ENTRY_W-1:0]  closest_index_o
);

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [ENTRY_W:0]   NUM_ENTRIES = (ENTRY_W+1)'(PALETTE_ENTRIES);
  localparam logic [ENTRY_W-1:0] MAX_IDX     = ENTRY_W'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W-1:0]   MAX_ADDR    = IDX_W'(PALETTE_ENTRIES - 1);

  state_e state_q, state_d;

  logic [ENTRY_W-1:0] cfg_q;
  logic [IDX_W-1:0]   last_q, last_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  rgb_t               query_q, query_d;

  token_t             p1_q, p1_d;   // palette read data valid
  token_t             p2_q;         // squared differences valid

  logic [DIST_W-1:0]  cur_dist;
  logic [DIST_W-1:0]  best_dist_q;
  logic [IDX_W-1:0]   best_idx_q;

  logic               out_valid_q;
  logic [ENTRY_W-1:0] out_idx_q;

  logic               in_xfer;
  logic               out_free;
  logic               out_load;
  logic               mem_we;
  rgb_t               mem_wdata;
  rgb_t               mem_rdata;

  // config register, write data taken whenever valid
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SEARCH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // bound clamped to the palette size
  assign last_d = (cfg_q > MAX_IDX) ? MAX_ADDR : cfg_q[IDX_W-1:0];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // palette writes go straight to memory in the transfer cycle
  assign mem_we    = in_xfer && (op_i == OP_WRITE) && ({1'b0, entry_index_i} < NUM_ENTRIES);
  assign mem_wdata = '{red:   sat_channel(red_i),
                       green: sat_channel(green_i),
                       blue:  sat_channel(blue_i)};

  npcs_palette_mem #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (entry_index_i[IDX_W-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q),
    .rdata_o (mem_rdata)
  );

  npcs_dist_unit u_dist (
    .clk_i   (clk_i),
    .entry_i (mem_rdata),
    .query_i (query_q),
    .dist_o  (cur_dist)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    query_d  = query_q;
    p1_d     = '{valid: 1'b0, idx: ENTRY_W'(cnt_q)};
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (op_i == OP_QUERY)) begin
          cnt_d   = '0;
          query_d = '{red: red_i[CH_W-1:0], green: green_i[CH_W-1:0],
                      blue: blue_i[CH_W-1:0]};
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // one palette read per cycle
        p1_d.valid = 1'b1;
        if (cnt_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!p1_q.valid && !p2_q.valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p1_q    <= '0;
      p2_q    <= '0;
    end else begin
      state_q <= state_d;
      p1_q    <= p1_d;
      p2_q    <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    query_q <= query_d;
    if (in_xfer) begin
      last_q <= last_d;
    end
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk_i) begin
    if (p2_q.valid && ((p2_q.idx == '0) || (cur_dist < best_dist_q))) begin
      best_dist_q <= cur_dist;
      best_idx_q  <= p2_q.idx[IDX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q <= ENTRY_W'(best_idx_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign closest_index_o = out_idx_q;

  // the read counter never passes the bound
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (cnt_q <= last_q))
    else $error("read counter beyond search bound");

  // reads are in flight only while a query is searching
  a_pipe_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_q.valid || p2_q.valid) |-> ((state_q == ST_SEARCH) || (state_q == ST_DRAIN)))
    else $error("palette read in flight outside a search");

  // a delivered index lies inside the searched range
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (best_idx_q <= last_q))
    else $error("result index beyond search bound");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("pending result overwritten");

endmodule

// ===== tb/palette_search_monitor.sv =====
`timescale 1ns / 1ps

module palette_search_monitor import npcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [ENTRY_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               op_i,
  input  logic [ENTRY_W-1:0] entry_index_i,
  input  logic [ENTRY_W-1:0] red_i,
  input  logic [ENTRY_W-1:0] green_i,
  input  logic [ENTRY_W-1:0] blue_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ENTRY_W-1:0] closest_index_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        queries_pending_o
);

  rgb_t               shadow_palette [256];
  logic [ENTRY_W-1:0] search_bound;
  logic [ENTRY_W-1:0] expected_index_q [$];
  logic [ENTRY_W-1:0] expected_index;
  rgb_t               item_color;

  function automatic logic [CH_W-1:0] clip_channel(input logic [ENTRY_W-1:0] v);
    return (v > ENTRY_W'(CHANNEL_MAX)) ? CHANNEL_MAX : v[CH_W-1:0];
  endfunction

  function automatic int unsigned color_distance(input rgb_t a, input rgb_t b);
    int dr, dg, db;
    dr = int'(a.red) - int'(b.red);
    dg = int'(a.green) - int'(b.green);
    db = int'(a.blue) - int'(b.blue);
    return dr * dr + dg * dg + db * db;
  endfunction

  // lowest index wins on equal distance
  function automatic logic [ENTRY_W-1:0] nearest_entry(input rgb_t q);
    int unsigned best_dist, d;
    logic [ENTRY_W-1:0] best;
    best = '0;
    best_dist = color_distance(shadow_palette[0], q);
    for (int unsigned i = 1; i <= int'(search_bound); i++) begin
      d = color_distance(shadow_palette[i], q);
      if (d < best_dist) begin
        best_dist = d;
        best = ENTRY_W'(i);
      end
    end
    return best;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_bound = SEARCH_RESET;
      expected_index_q.delete();
      foreach (shadow_palette[i]) shadow_palette[i] = '0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) search_bound = cfg_data_i;

      if (out_valid_i && !out_stall_i) begin
        if (expected_index_q.size() == 0) begin
          $error("closest_index: result with no query waiting, expected none, actual %0d",
                 closest_index_i);
          mismatch_count_o++;
        end else begin
          expected_index = expected_index_q.pop_front();
          if (closest_index_i !== expected_index) begin
            $error("closest_index mismatch: expected %0d, actual %0d",
                   expected_index, closest_index_i);
            mismatch_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_WRITE) begin
          item_color.red   = clip_channel(red_i);
          item_color.green = clip_channel(green_i);
          item_color.blue  = clip_channel(blue_i);
          shadow_palette[entry_index_i] = item_color;
        end else begin
          item_color.red   = red_i[CH_W-1:0];
          item_color.green = green_i[CH_W-1:0];
          item_color.blue  = blue_i[CH_W-1:0];
          expected_index_q.push_back(nearest_entry(item_color));
        end
      end
    end
    queries_pending_o = expected_index_q.size();
  end

endmodule

// ===== tb/nearest_palette_color_search_tb.sv =====
`timescale 1ns / 1ps

module nearest_palette_color_search_tb;
  import npcs_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int unsigned STUCK_LIMIT = 4000;
  // one long receiver hold-off to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned HOLD_AFTER_RESULTS = 60;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ENTRY_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_WRITE;
  logic [ENTRY_W-1:0] entry_index = '0;
  logic [ENTRY_W-1:0] red = '0;
  logic [ENTRY_W-1:0] green = '0;
  logic [ENTRY_W-1:0] blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ENTRY_W-1:0] closest_index;

  int unsigned mismatch_count;
  int unsigned queries_pending;
  int unsigned results_taken = 0;
  int unsigned stuck_cycles = 0;

  // stimulus bookkeeping: which entries hold a color, and which color
  bit          entry_written [256];
  rgb_t        palette_copy [256];
  int unsigned cur_bound = SEARCH_RESET;
  int unsigned back_to_back_left = 0;

  nearest_palette_color_search dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op),
    .entry_index_i   (entry_index),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .closest_index_o (closest_index)
  );

  palette_search_monitor monitor (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .op_i              (op),
    .entry_index_i     (entry_index),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .closest_index_i   (closest_index),
    .mismatch_count_o  (mismatch_count),
    .queries_pending_o (queries_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (out_valid && !out_stall) results_taken <= results_taken + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // channel values lean on the saturation and masking corners
  function automatic logic [ENTRY_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd63;
      2: return 8'd64;
      3: return 8'd255;
      default: return ENTRY_W'($urandom_range(0, 255));
    endcase
  endfunction

  // result sink: random stall stretches, one long hold-off once results flow
  initial begin : result_sink
    int unsigned stall_len, free_len;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!held && results_taken >= HOLD_AFTER_RESULTS) begin
        stall_len = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        stall_len = idle_length();
      end
      // occasional long stretch with no stall at all
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
    end
  end

  // present one item and return at the edge where it is transferred;
  // stall is sampled mid-cycle where the block's outputs are settled
  task automatic offer_item(input op_e code, input logic [ENTRY_W-1:0] idx,
                            input logic [ENTRY_W-1:0] r, input logic [ENTRY_W-1:0] g,
                            input logic [ENTRY_W-1:0] b);
    int unsigned gap;
    bit taken;
    if (back_to_back_left != 0) begin
      back_to_back_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) back_to_back_left = $urandom_range(10, 40);
      gap = idle_length();
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= code;
    entry_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_entry(input logic [ENTRY_W-1:0] idx, input logic [ENTRY_W-1:0] r,
                             input logic [ENTRY_W-1:0] g, input logic [ENTRY_W-1:0] b);
    offer_item(OP_WRITE, idx, r, g, b);
    entry_written[idx] = 1'b1;
    palette_copy[idx].red   = (r > 8'd63) ? CHANNEL_MAX : r[CH_W-1:0];
    palette_copy[idx].green = (g > 8'd63) ? CHANNEL_MAX : g[CH_W-1:0];
    palette_copy[idx].blue  = (b > 8'd63) ? CHANNEL_MAX : b[CH_W-1:0];
  endtask

  // entry_index is don't-care for a query, so it gets noise
  task automatic query_color(input logic [ENTRY_W-1:0] r, input logic [ENTRY_W-1:0] g,
                             input logic [ENTRY_W-1:0] b);
    offer_item(OP_QUERY, ENTRY_W'($urandom_range(0, 255)), r, g, b);
  endtask

  // new bound only once the block is idle, then fill every entry the
  // search will read so no query touches an unwritten entry
  task automatic set_search_bound(input int unsigned bound);
    bit taken;
    in_valid <= 1'b0;
    // let the monitor count the last transfer first
    @(negedge clk);
    while (queries_pending != 0) @(negedge clk);
    repeat (cur_bound + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ENTRY_W'(bound);
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    cur_bound = bound;
    for (int unsigned i = 0; i <= bound; i++) begin
      if (!entry_written[i]) begin
        write_entry(ENTRY_W'(i), random_channel(), random_channel(), random_channel());
      end
    end
  endtask

  // mostly queries against the live palette, with exact hits and
  // duplicated colors to force ties
  task automatic random_phase(input int unsigned count);
    int unsigned roll;
    rgb_t c;
    logic [1:0] hr, hg, hb;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      c = palette_copy[$urandom_range(0, cur_bound)];
      hr = 2'($urandom_range(0, 3));
      hg = 2'($urandom_range(0, 3));
      hb = 2'($urandom_range(0, 3));
      if (roll < 45) begin
        query_color(random_channel(), random_channel(), random_channel());
      end else if (roll < 60) begin
        // exact hit, upper bits must be dropped by the query mask
        query_color({hr, c.red}, {hg, c.green}, {hb, c.blue});
      end else if (roll < 85) begin
        write_entry(ENTRY_W'($urandom_range(0, 255)), random_channel(), random_channel(),
                    random_channel());
      end else begin
        write_entry(ENTRY_W'($urandom_range(0, 255)), {2'b00, c.red}, {2'b00, c.green},
                    {2'b00, c.blue});
      end
    end
  endtask

  initial begin : stimulus
    foreach (entry_written[i]) entry_written[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-entry palette: saturation, masking, ties, exact hits
    set_search_bound(1);
    write_entry(8'd0, 8'd0, 8'd0, 8'd0);
    write_entry(8'd1, 8'd255, 8'd255, 8'd255);
    query_color(8'd0, 8'd0, 8'd0);
    query_color(8'd63, 8'd63, 8'd63);
    query_color(8'd255, 8'd255, 8'd255);
    query_color(8'd64, 8'd64, 8'd64);
    query_color(8'd32, 8'd31, 8'd31);
    query_color(8'd31, 8'd32, 8'd32);
    // equal entries: lowest index must win
    write_entry(8'd1, 8'd0, 8'd0, 8'd0);
    query_color(8'd10, 8'd20, 8'd30);
    write_entry(8'd1, 8'd64, 8'd63, 8'd100);
    write_entry(8'd0, 8'd63, 8'd0, 8'd0);
    // entries above the bound are never returned
    write_entry(8'd255, 8'd1, 8'd2, 8'd3);
    write_entry(8'd128, 8'd0, 8'd63, 8'd63);
    query_color(8'd1, 8'd2, 8'd3);
    query_color(8'd63, 8'd0, 8'd0);
    query_color(8'd0, 8'd127, 8'd191);
    write_entry(8'd0, 8'd62, 8'd63, 8'd64);
    query_color(8'd62, 8'd63, 8'd63);

    // bound of zero: only entry 0 is searched
    set_search_bound(0);
    query_color(8'd63, 8'd63, 8'd63);
    query_color(8'd0, 8'd0, 8'd0);
    random_phase(20);

    set_search_bound(2);
    random_phase(75);
    set_search_bound(15);
    random_phase(75);
    set_search_bound(255);
    random_phase(70);
    set_search_bound(63);
    random_phase(80);
    set_search_bound(SEARCH_RESET);
    random_phase(70);
    set_search_bound(31);
    random_phase(80);
    set_search_bound($urandom_range(1, 255));
    random_phase(75);
    set_search_bound(1);
    random_phase(80);
    set_search_bound(7);
    random_phase(75);

    in_valid <= 1'b0;
    // let the monitor count the last transfer first
    @(negedge clk);
    while (queries_pending != 0) @(negedge clk);
    repeat (cur_bound + 10) @(posedge clk);
    if (mismatch_count == 0 && queries_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
